@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the deframer modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent now, consequent in the cycle after.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  localparam int HEADER_BYTES = 8;
  localparam int MAX_RESULTS  = 3;

  localparam logic [3:0] HDR_LAST_COUNT = 4'(HEADER_BYTES - 1);
  localparam logic [3:0] SID_DONE_COUNT = 4'(HEADER_BYTES + 4);

  localparam logic [23:0] DEFAULT_MAX_CONTROL = 24'(64 * 1024);

  // control frame types
  localparam logic [15:0] T_SYN_STREAM = 16'd1;
  localparam logic [15:0] T_SYN_REPLY  = 16'd2;
  localparam logic [15:0] T_FIN_STREAM = 16'd3;
  localparam logic [15:0] T_NOOP       = 16'd4;

  // error codes
  localparam logic [1:0] ERR_UNKNOWN_TYPE = 2'd0;
  localparam logic [1:0] ERR_BAD_LENGTH   = 2'd1;
  localparam logic [1:0] ERR_TOO_LARGE    = 2'd2;
  localparam logic [1:0] ERR_BAD_VERSION  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_EXPECTED_VERSION = 3'd0;
  localparam logic [2:0] CFG_MAX_CONTROL      = 3'd1;
  localparam logic [2:0] CFG_SYN_STREAM_MIN   = 3'd2;
  localparam logic [2:0] CFG_SYN_REPLY_MIN    = 3'd3;
  localparam logic [2:0] CFG_FIN_STREAM_LEN   = 3'd4;

  typedef enum logic [2:0] {
    EV_DATA       = 3'd0,
    EV_CTRL_BYTE  = 3'd1,
    EV_CTRL_DONE  = 3'd2,
    EV_STREAM_END = 3'd3,
    EV_ERROR      = 3'd4
  } event_kind_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_DATA    = 3'd1,
    PH_CONTROL = 3'd2,
    PH_SKIP    = 3'd3,
    PH_ERROR   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [14:0] expected_version;
    logic [23:0] max_control_payload;
    logic [7:0]  syn_stream_min_payload;
    logic [7:0]  syn_reply_min_payload;
    logic [7:0]  fin_stream_payload;
  } cfg_t;

  // All results caused by one input byte; they share stream id and byte.
  typedef struct packed {
    logic [1:0]                        count;
    event_kind_t [MAX_RESULTS-1:0]     kinds;
    logic [30:0]                       frame_sid;
    logic [7:0]                        payload_byte;
    logic [15:0]                       control_type;
    logic [1:0]                        fault_code;
    logic                              is_compressed;
  } bundle_t;

endpackage

`default_nettype wire

@@ rtl/sfd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sfd_cfg_regs
// Configuration registers, written through a plain index/data write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfd_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_write_en,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [23:0]  cfg_data,
  output sfd_pkg::cfg_t     cfg
);
  import sfd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version       <= 15'd1;
      cfg.max_control_payload    <= DEFAULT_MAX_CONTROL;
      cfg.syn_stream_min_payload <= 8'd6;
      cfg.syn_reply_min_payload  <= 8'd6;
      cfg.fin_stream_payload     <= 8'd8;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_EXPECTED_VERSION: cfg.expected_version       <= cfg_data[14:0];
        CFG_MAX_CONTROL:      cfg.max_control_payload    <= cfg_data;
        CFG_SYN_STREAM_MIN:   cfg.syn_stream_min_payload <= cfg_data[7:0];
        CFG_SYN_REPLY_MIN:    cfg.syn_reply_min_payload  <= cfg_data[7:0];
        CFG_FIN_STREAM_LEN:   cfg.fin_stream_payload     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/sfd_parser.sv @@
// ----------------------------------------------------------------------------
// sfd_parser
// Frame state and per-byte decode: builds the result bundle for one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfd_parser (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [7:0]   stream_byte,
  input  sfd_pkg::cfg_t     cfg,
  output sfd_pkg::bundle_t  bundle
);
  import sfd_pkg::*;

  `include "assert_macros.svh"

  logic [63:0] header_store, header_store_next;
  logic [3:0]  header_count, header_count_next;
  phase_t      phase, phase_next;
  logic [23:0] bytes_remaining, bytes_remaining_next;
  logic [30:0] ctrl_sid, ctrl_sid_next;

  logic [63:0] h;
  logic [23:0] rem_dec;
  logic [30:0] sid_cur;
  logic        restart;
  logic        bad;
  logic [1:0]  code;

  assign h       = {header_store[55:0], stream_byte};
  assign rem_dec = bytes_remaining - 24'd1;

  // header checks; the last failing check sets the code
  always_comb begin
    bad  = 1'b0;
    code = ERR_UNKNOWN_TYPE;
    unique case (h[47:32])
      T_SYN_STREAM: if (h[23:0] < {16'd0, cfg.syn_stream_min_payload}) begin
        bad  = 1'b1;
        code = ERR_BAD_LENGTH;
      end
      T_SYN_REPLY: if (h[23:0] < {16'd0, cfg.syn_reply_min_payload}) begin
        bad  = 1'b1;
        code = ERR_BAD_LENGTH;
      end
      T_FIN_STREAM: if (h[23:0] != {16'd0, cfg.fin_stream_payload}) begin
        bad  = 1'b1;
        code = ERR_BAD_LENGTH;
      end
      T_NOOP: ;
      default: begin
        bad  = 1'b1;
        code = ERR_UNKNOWN_TYPE;
      end
    endcase
    if (h[62:48] != cfg.expected_version) begin
      bad  = 1'b1;
      code = ERR_BAD_VERSION;
    end
    if (h[23:0] > cfg.max_control_payload) begin
      bad  = 1'b1;
      code = ERR_TOO_LARGE;
    end
  end

  always_comb begin
    header_store_next    = header_store;
    header_count_next    = header_count;
    phase_next           = phase;
    bytes_remaining_next = bytes_remaining;
    ctrl_sid_next        = ctrl_sid;
    restart              = 1'b0;
    bundle               = '0;
    sid_cur              = ctrl_sid;

    unique case (phase)
      PH_HEADER: begin
        header_store_next = h;
        header_count_next = header_count + 4'd1;
        if (header_count == HDR_LAST_COUNT) begin
          if (!h[63]) begin
            if (h[23:0] == 24'd0) begin
              if (h[24]) begin
                bundle.count     = 2'd1;
                bundle.kinds[0]  = EV_STREAM_END;
                bundle.frame_sid = h[62:32];
              end
              restart = 1'b1;
            end else begin
              bytes_remaining_next = h[23:0];
              phase_next           = PH_DATA;
            end
          end else if (h[47:32] == T_NOOP) begin
            // swallowed silently, payload skipped
            if (h[23:0] == 24'd0) begin
              restart = 1'b1;
            end else begin
              bytes_remaining_next = h[23:0];
              phase_next           = PH_SKIP;
            end
          end else if (bad) begin
            bundle.count      = 2'd1;
            bundle.kinds[0]   = EV_ERROR;
            bundle.fault_code = code;
            phase_next        = PH_ERROR;
          end else if (h[23:0] == 24'd0) begin
            bundle.kinds[0]     = EV_CTRL_DONE;
            bundle.control_type = h[47:32];
            if (h[47:32] == T_SYN_REPLY && h[24]) begin
              bundle.count    = 2'd2;
              bundle.kinds[1] = EV_STREAM_END;
            end else begin
              bundle.count = 2'd1;
            end
            restart = 1'b1;
          end else begin
            bytes_remaining_next = h[23:0];
            ctrl_sid_next        = '0;
            phase_next           = PH_CONTROL;
          end
        end
      end

      PH_DATA: begin
        bundle.count         = 2'd1;
        bundle.kinds[0]      = EV_DATA;
        bundle.frame_sid     = header_store[62:32];
        bundle.payload_byte  = stream_byte;
        bundle.is_compressed = header_store[25];
        bytes_remaining_next = rem_dec;
        if (rem_dec == 24'd0) begin
          if (header_store[24]) begin
            bundle.count    = 2'd2;
            bundle.kinds[1] = EV_STREAM_END;
          end
          restart = 1'b1;
        end
      end

      PH_CONTROL: begin
        // first four payload bytes carry the stream id
        if (header_count < SID_DONE_COUNT) begin
          sid_cur           = {ctrl_sid[22:0], stream_byte};
          header_count_next = header_count + 4'd1;
        end
        ctrl_sid_next        = sid_cur;
        bundle.count         = 2'd1;
        bundle.kinds[0]      = EV_CTRL_BYTE;
        bundle.frame_sid     = sid_cur;
        bundle.payload_byte  = stream_byte;
        bytes_remaining_next = rem_dec;
        if (rem_dec == 24'd0) begin
          bundle.count        = 2'd2;
          bundle.kinds[1]     = EV_CTRL_DONE;
          bundle.control_type = header_store[47:32];
          if (header_store[47:32] == T_SYN_REPLY && header_store[24]) begin
            bundle.count    = 2'd3;
            bundle.kinds[2] = EV_STREAM_END;
          end
          restart = 1'b1;
        end
      end

      PH_SKIP: begin
        bytes_remaining_next = rem_dec;
        if (rem_dec == 24'd0) begin
          restart = 1'b1;
        end
      end

      PH_ERROR: ;

      default: ;
    endcase

    if (restart) begin
      header_store_next    = '0;
      header_count_next    = '0;
      bytes_remaining_next = '0;
      ctrl_sid_next        = '0;
      phase_next           = PH_HEADER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_store    <= '0;
      header_count    <= '0;
      phase           <= PH_HEADER;
      bytes_remaining <= '0;
      ctrl_sid        <= '0;
    end else if (accept) begin
      header_store    <= header_store_next;
      header_count    <= header_count_next;
      phase           <= phase_next;
      bytes_remaining <= bytes_remaining_next;
      ctrl_sid        <= ctrl_sid_next;
    end
  end

  `SFD_ASSERT_NEXT(a_error_sticks, phase == PH_ERROR, phase == PH_ERROR,
                   "error phase left without reset")
  `SFD_ASSERT_IMP(a_count_range, 1'b1, header_count <= SID_DONE_COUNT,
                  "header count past stream id bytes")
  `SFD_ASSERT_IMP(a_payload_left, phase == PH_DATA || phase == PH_CONTROL,
                  bytes_remaining != 24'd0, "payload phase with nothing left")

endmodule

`default_nettype wire

@@ rtl/sfd_out_queue.sv @@
// ----------------------------------------------------------------------------
// sfd_out_queue
// Holds the result bundle of one byte and sends its results one beat each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfd_out_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  sfd_pkg::bundle_t   bundle,
  output logic               can_load,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         event_kind,
  output logic [30:0]        frame_sid,
  output logic [7:0]         payload_byte,
  output logic [15:0]        control_type,
  output logic [1:0]         fault_code,
  output logic               is_compressed,
  output logic               last_of_run
);
  import sfd_pkg::*;

  `include "assert_macros.svh"

  bundle_t     burst;
  logic        busy;
  logic [1:0]  idx;
  logic        take;
  logic        last;
  event_kind_t kind;

  assign out_valid = busy;
  assign take      = busy && !out_stall;
  assign last      = idx == (burst.count - 2'd1);
  assign can_load  = !busy || (take && last);
  assign kind      = burst.kinds[idx];

  always_comb begin
    event_kind    = kind;
    frame_sid     = burst.frame_sid;
    last_of_run   = last;
    payload_byte  = (kind == EV_DATA || kind == EV_CTRL_BYTE) ? burst.payload_byte : 8'd0;
    control_type  = (kind == EV_CTRL_DONE) ? burst.control_type : 16'd0;
    fault_code    = (kind == EV_ERROR) ? burst.fault_code : 2'd0;
    is_compressed = (kind == EV_DATA) ? burst.is_compressed : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst <= bundle;
    end
  end

  `SFD_ASSERT_IMP(a_load_when_free, load, can_load && bundle.count != 2'd0,
                  "bundle loaded over pending results")
  `SFD_ASSERT_IMP(a_idx_in_burst, busy, idx < burst.count,
                  "beat index beyond bundle")
  `SFD_ASSERT_NEXT(a_hold_on_stall, busy && out_stall, busy && $stable(idx),
                   "result dropped while stalled")

endmodule

`default_nettype wire

@@ rtl/spdy_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// spdy_frame_deframer
// Byte-serial frame deframer: header gather, checks and result events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one stream byte per beat.
//   Output channel (out_valid / out_stall) carries one event per beat; the
//   last event caused by one input byte has last_of_run set.
//   Each byte is decoded in the cycle it is accepted; its events appear on
//   the output from the next cycle on.
//   A byte yields zero to three events. Bytes producing at most one event
//   are taken every cycle while out_stall is low; a byte producing more
//   holds the input while the single output register drains them, one a beat.
//   The next byte is accepted in the same cycle the last pending event
//   leaves, so a waiting byte that yields events keeps the register full.
//   A stalled receiver holds the current event; the input stalls once the
//   pending events are not drained.
//   Reset (rst, synchronous) restores register defaults, drops pending
//   events and restarts at a frame header. After a header error the block
//   keeps taking bytes but reports nothing until reset.
//   Configuration writes (cfg_write_en) are to be made only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spdy_frame_deframer (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_write_en,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [23:0]  cfg_data,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   stream_byte,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [2:0]        event_kind,
  output logic [30:0]       frame_sid,
  output logic [7:0]        payload_byte,
  output logic [15:0]       control_type,
  output logic [1:0]        fault_code,
  output logic              is_compressed,
  output logic              last_of_run
);
  import sfd_pkg::*;

  cfg_t    cfg;
  bundle_t bundle;
  logic    can_load;
  logic    accept;
  logic    load;

  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;
  assign load     = accept && (bundle.count != 2'd0);

  sfd_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  sfd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .stream_byte (stream_byte),
    .cfg         (cfg),
    .bundle      (bundle)
  );

  sfd_out_queue u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .bundle        (bundle),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind    (event_kind),
    .frame_sid     (frame_sid),
    .payload_byte  (payload_byte),
    .control_type  (control_type),
    .fault_code    (fault_code),
    .is_compressed (is_compressed),
    .last_of_run   (last_of_run)
  );

endmodule

`default_nettype wire
